[rtl/core/postfix_expression_evaluator_top_defines.svh]
// ============================================================================
// Assertion macros for the postfix evaluator.
// Shared property wrappers used by the RTL files that carry assertions.
// ============================================================================
`ifndef POSTFIX_EXPRESSION_EVALUATOR_TOP_DEFINES_SVH
`define POSTFIX_EXPRESSION_EVALUATOR_TOP_DEFINES_SVH

// Implication checked on every edge outside reset.
`define PEE_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("postfix evaluator check failed");

// Implication whose consequent is checked in the cycle after the antecedent.
`define PEE_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("postfix evaluator check failed");

`endif

[rtl/core/pee_pkg.sv]
// ============================================================================
// pee_pkg
// Types and constants shared by the postfix evaluator modules.
// ============================================================================
package pee_pkg;

    localparam int STACK_DEPTH = 64;
    localparam int FRAC_BITS   = 16;
    localparam int PTR_W       = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int CNT_W       = 8;
    localparam int DIV_W       = 32 + FRAC_BITS;

    localparam int FLG_BAD   = 0;
    localparam int FLG_UNDER = 1;
    localparam int FLG_FULL  = 2;
    localparam int FLG_DIV0  = 3;
    localparam int FLG_SAT   = 4;

    localparam logic [7:0] SYM_SPACE = 8'h20;
    localparam logic [7:0] SYM_ADD   = 8'h2B;
    localparam logic [7:0] SYM_SUB   = 8'h2D;
    localparam logic [7:0] SYM_MUL   = 8'h2A;
    localparam logic [7:0] SYM_DIV   = 8'h2F;
    localparam logic [7:0] SYM_POW   = 8'h5E;
    localparam logic [7:0] SYM_ZERO  = 8'h30;
    localparam logic [7:0] SYM_NINE  = 8'h39;

    localparam logic signed [31:0] VAL_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;

    typedef enum logic [2:0] {
        OP_ADD,
        OP_SUB,
        OP_MUL,
        OP_DIV,
        OP_POW
    } op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_READ_B,
        ST_READ_A,
        ST_EXEC,
        ST_MUL,
        ST_DIV,
        ST_DIV_END,
        ST_WRITE,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic start;
        logic is_div;
        logic signed [31:0] a;
        logic signed [31:0] b;
        logic signed [31:0] m;
    } alu_req_t;

    typedef struct packed {
        logic done;
        logic sat;
        logic signed [31:0] r;
    } alu_rsp_t;

    function automatic logic signed [31:0] clip32(input logic signed [64:0] v,
                                                 output logic sat);
        begin
            sat = 1'b0;
            if (v > 65'sd2147483647) begin
                sat = 1'b1;
                clip32 = VAL_MAX;
            end else if (v < -65'sd2147483648) begin
                sat = 1'b1;
                clip32 = VAL_MIN;
            end else begin
                clip32 = v[31:0];
            end
        end
    endfunction

endpackage

[rtl/core/pee_alu.sv]
// ============================================================================
// pee_alu
// Multicycle fixed-point unit: one registered multiply, or a restoring
// divider that resolves one quotient bit per cycle.
// ============================================================================
module pee_alu (
    input  logic              aclk,
    input  logic              aresetn,
    input  pee_pkg::alu_req_t req,
    output pee_pkg::alu_rsp_t rsp
);
    import pee_pkg::*;

    logic              busy_reg, busy_next;
    logic              div_reg, div_next;
    logic [5:0]        cnt_reg, cnt_next;
    logic              neg_reg, neg_next;
    logic [63:0]       prod_reg, prod_next;
    logic [DIV_W-1:0]  num_reg, num_next;
    logic [31:0]       rem_reg, rem_next;
    logic [31:0]       den_reg, den_next;
    logic [DIV_W-1:0]  quo_reg, quo_next;
    logic [32:0]       trial;
    logic [31:0]       mag_a, mag_b, mag_m;
    logic [64:0]       sval;
    logic              sat_w;

    assign mag_a = req.a[31] ? 32'(-req.a) : 32'(req.a);
    assign mag_b = req.b[31] ? 32'(-req.b) : 32'(req.b);
    assign mag_m = req.m[31] ? 32'(-req.m) : 32'(req.m);
    assign trial = {rem_reg, num_reg[DIV_W-1]};

    always_comb begin
        busy_next = busy_reg;
        div_next  = div_reg;
        cnt_next  = cnt_reg;
        neg_next  = neg_reg;
        prod_next = prod_reg;
        num_next  = num_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        quo_next  = quo_reg;
        rsp       = '0;
        sval      = '0;
        sat_w     = 1'b0;
        if (busy_reg) begin
            if (div_reg && cnt_reg != '0) begin
                if (trial >= {1'b0, den_reg}) begin
                    rem_next = 32'(trial - {1'b0, den_reg});
                    quo_next = {quo_reg[DIV_W-2:0], 1'b1};
                end else begin
                    rem_next = trial[31:0];
                    quo_next = {quo_reg[DIV_W-2:0], 1'b0};
                end
                num_next = {num_reg[DIV_W-2:0], 1'b0};
                cnt_next = cnt_reg - 6'd1;
            end else begin
                busy_next = 1'b0;
                rsp.done  = 1'b1;
                if (div_reg) begin
                    sval = neg_reg ? -65'($unsigned(quo_reg)) : 65'($unsigned(quo_reg));
                end else begin
                    sval = neg_reg ? -65'(prod_reg >> FRAC_BITS)
                                   : 65'(prod_reg >> FRAC_BITS);
                end
                rsp.r   = clip32(sval, sat_w);
                rsp.sat = sat_w;
            end
        end
        if (req.start) begin
            busy_next = 1'b1;
            div_next  = req.is_div;
            if (req.is_div) begin
                neg_next = req.a[31] ^ req.b[31];
                num_next = {mag_a, {FRAC_BITS{1'b0}}};
                den_next = mag_b;
                rem_next = '0;
                quo_next = '0;
                cnt_next = 6'(DIV_W);
            end else begin
                neg_next  = req.m[31] ^ req.b[31];
                prod_next = 64'(mag_m) * 64'(mag_b);
                cnt_next  = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
        end
        div_reg  <= div_next;
        cnt_reg  <= cnt_next;
        neg_reg  <= neg_next;
        prod_reg <= prod_next;
        num_reg  <= num_next;
        rem_reg  <= rem_next;
        den_reg  <= den_next;
        quo_reg  <= quo_next;
    end

endmodule

[rtl/core/pee_stack.sv]
// ============================================================================
// pee_stack
// Operand stack storage: one write port and one read port with a
// registered read.
// ============================================================================
module pee_stack (
    input  logic                       aclk,
    input  logic                       we,
    input  logic [pee_pkg::ADDR_W-1:0] waddr,
    input  logic [31:0]                wdata,
    input  logic [pee_pkg::ADDR_W-1:0] raddr,
    output logic [31:0]                rdata
);
    import pee_pkg::*;

    logic [31:0] mem [STACK_DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[rtl/core/postfix_expression_evaluator_top.sv]
// ============================================================================
// postfix_expression_evaluator_top
// Postfix evaluator on signed Q16.16 operands held in an operand stack RAM.
//
//  Channel | Dir | Word
//  s_axis  | in  | tdata = symbol[7:0], tlast = last
//  m_axis  | out | tdata = value[31:0], tuser = flags[4:0]
//
// Digits, spaces and operators without two operands are handled in the idle state.
// + and - pass READ_B, READ_A, EXEC and WRITE; * adds MUL, / adds DIV and DIV_END.
// Power runs up to 255 multiplications in MUL; a zero divisor skips the divider.
// Operands come through the registered stack RAM read port; the divider resolves
// one quotient bit per cycle. The stack needs no clearing pass after reset.
// A last word passes through the emit state and is held off while a result word waits.
// ============================================================================
`include "postfix_expression_evaluator_top_defines.svh"

module postfix_expression_evaluator_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // symbol[7:0]
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // value[31:0]
    output logic [4:0]  m_axis_tuser    // saturated, div_by_zero, stack_full, underflow, bad_symbol
);
    import pee_pkg::*;

    state_t             state_reg, state_next;
    logic [PTR_W-1:0]   sp_reg, sp_next;
    logic [31:0]        res_reg, res_next;
    logic [4:0]         flg_reg, flg_next;
    logic               last_reg, last_next;
    op_t                op_reg, op_next;
    logic signed [31:0] a_reg, a_next;
    logic signed [31:0] b_reg, b_next;
    logic signed [31:0] r_reg, r_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               ovalid_reg, ovalid_next;
    logic [31:0]        odata_reg, odata_next;
    logic [4:0]         ouser_reg, ouser_next;

    logic               we;
    logic [ADDR_W-1:0]  waddr, raddr;
    logic [31:0]        wdata, rdata;
    alu_req_t           areq;
    alu_rsp_t           arsp;
    logic               acc, is_digit, is_op, sat_w;
    logic signed [64:0] sum;
    logic [31:0]        ceil_b;

    pee_stack u_stack (
        .aclk (aclk), .we (we), .waddr (waddr), .wdata (wdata),
        .raddr (raddr), .rdata (rdata)
    );

    pee_alu u_alu (.aclk (aclk), .aresetn (aresetn), .req (areq), .rsp (arsp));

    assign s_axis_tready = (state_reg == ST_IDLE) && !(ovalid_reg && s_axis_tlast);
    assign acc = s_axis_tvalid && s_axis_tready;
    assign is_digit = (s_axis_tdata >= SYM_ZERO) && (s_axis_tdata <= SYM_NINE);
    assign is_op = (s_axis_tdata == SYM_ADD) || (s_axis_tdata == SYM_SUB) ||
                   (s_axis_tdata == SYM_MUL) || (s_axis_tdata == SYM_DIV) ||
                   (s_axis_tdata == SYM_POW);
    assign ceil_b = 32'(b_reg) + 32'((1 << FRAC_BITS) - 1);
    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata  = odata_reg;
    assign m_axis_tuser  = ouser_reg;

    always_comb begin
        state_next  = state_reg;
        sp_next     = sp_reg;
        res_next    = res_reg;
        flg_next    = flg_reg;
        last_next   = last_reg;
        op_next     = op_reg;
        a_next      = a_reg;
        b_next      = b_reg;
        r_next      = r_reg;
        cnt_next    = cnt_reg;
        ovalid_next = ovalid_reg;
        odata_next  = odata_reg;
        ouser_next  = ouser_reg;
        we          = 1'b0;
        waddr       = sp_reg[ADDR_W-1:0];
        wdata       = '0;
        raddr       = ADDR_W'(sp_reg - PTR_W'(1));
        areq        = '0;
        sum         = '0;
        sat_w       = 1'b0;
        if (ovalid_reg && m_axis_tready) begin
            ovalid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE: begin
                if (acc) begin
                    last_next = s_axis_tlast;
                    state_next = s_axis_tlast ? ST_EMIT : ST_IDLE;
                    if (is_digit) begin
                        if (sp_reg >= PTR_W'(STACK_DEPTH)) begin
                            flg_next[FLG_FULL] = 1'b1;
                        end else begin
                            we = 1'b1;
                            wdata = 32'(s_axis_tdata - SYM_ZERO) << FRAC_BITS;
                            sp_next = sp_reg + PTR_W'(1);
                        end
                    end else if (is_op) begin
                        if (sp_reg < PTR_W'(2)) begin
                            flg_next[FLG_UNDER] = 1'b1;
                        end else begin
                            state_next = ST_READ_B;
                            unique case (s_axis_tdata)
                                SYM_ADD: op_next = OP_ADD;
                                SYM_SUB: op_next = OP_SUB;
                                SYM_MUL: op_next = OP_MUL;
                                SYM_DIV: op_next = OP_DIV;
                                default: op_next = OP_POW;
                            endcase
                        end
                    end else if (s_axis_tdata != SYM_SPACE) begin
                        flg_next[FLG_BAD] = 1'b1;
                    end
                end
            end
            ST_READ_B: begin
                b_next = rdata;
                raddr = ADDR_W'(sp_reg - PTR_W'(2));
                state_next = ST_READ_A;
            end
            ST_READ_A: begin
                raddr = ADDR_W'(sp_reg - PTR_W'(2));
                state_next = ST_EXEC;
            end
            ST_EXEC: begin
                a_next = rdata;
                r_next = rdata;
                unique case (op_reg) inside
                    OP_ADD, OP_SUB: begin
                        sum = (op_reg == OP_ADD) ? 65'(signed'(rdata)) + 65'(b_reg)
                                                 : 65'(signed'(rdata)) - 65'(b_reg);
                        r_next = clip32(sum, sat_w);
                        flg_next[FLG_SAT] = flg_reg[FLG_SAT] | sat_w;
                        state_next = ST_WRITE;
                    end
                    OP_MUL: begin
                        areq.start = 1'b1;
                        areq.m = rdata;
                        areq.b = b_reg;
                        cnt_next = CNT_W'(1);
                        state_next = ST_MUL;
                    end
                    OP_DIV: begin
                        if (b_reg == 32'sd0) begin
                            flg_next[FLG_DIV0] = 1'b1;
                            r_next = rdata[31] ? VAL_MIN :
                                     (rdata == '0) ? 32'sd0 : VAL_MAX;
                            state_next = ST_WRITE;
                        end else begin
                            areq.start = 1'b1;
                            areq.is_div = 1'b1;
                            areq.a = rdata;
                            areq.b = b_reg;
                            state_next = ST_DIV;
                        end
                    end
                    default: begin
                        if (b_reg > 32'sd0 && ceil_b[31:FRAC_BITS] > 32'd1) begin
                            cnt_next = (ceil_b[31:FRAC_BITS] - 32'd1 > 32'd255) ? CNT_W'(255)
                                     : CNT_W'(ceil_b[31:FRAC_BITS] - 32'd1);
                            areq.start = 1'b1;
                            areq.m = rdata;
                            areq.b = rdata;
                            state_next = ST_MUL;
                        end else begin
                            state_next = ST_WRITE;
                        end
                    end
                endcase
            end
            ST_MUL: begin
                if (arsp.done) begin
                    r_next = arsp.r;
                    flg_next[FLG_SAT] = flg_reg[FLG_SAT] | arsp.sat;
                    cnt_next = cnt_reg - CNT_W'(1);
                    if (cnt_reg == CNT_W'(1)) begin
                        state_next = ST_WRITE;
                    end else begin
                        areq.start = 1'b1;
                        areq.m = arsp.r;
                        areq.b = a_reg;
                    end
                end
            end
            ST_DIV: begin
                if (arsp.done) begin
                    r_next = arsp.r;
                    flg_next[FLG_SAT] = flg_reg[FLG_SAT] | arsp.sat;
                    state_next = ST_DIV_END;
                end
            end
            ST_DIV_END: begin
                state_next = ST_WRITE;
            end
            ST_WRITE: begin
                we = 1'b1;
                waddr = ADDR_W'(sp_reg - PTR_W'(2));
                wdata = r_reg;
                sp_next = sp_reg - PTR_W'(1);
                res_next = r_reg;
                state_next = last_reg ? ST_EMIT : ST_IDLE;
            end
            ST_EMIT: begin
                if (!ovalid_reg || m_axis_tready) begin
                    ovalid_next = 1'b1;
                    odata_next = res_reg;
                    ouser_next = flg_reg;
                    sp_next = '0;
                    res_next = '0;
                    flg_next = '0;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            sp_reg     <= '0;
            res_reg    <= '0;
            flg_reg    <= '0;
            ovalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            sp_reg     <= sp_next;
            res_reg    <= res_next;
            flg_reg    <= flg_next;
            ovalid_reg <= ovalid_next;
        end
        last_reg  <= last_next;
        op_reg    <= op_next;
        a_reg     <= a_next;
        b_reg     <= b_next;
        r_reg     <= r_next;
        cnt_reg   <= cnt_next;
        odata_reg <= odata_next;
        ouser_reg <= ouser_next;
    end

    `PEE_ASSERT_IMPL(a_sp_range, aclk, aresetn, 1'b1, sp_reg <= PTR_W'(STACK_DEPTH))
    `PEE_ASSERT_IMPL(a_ready_idle, aclk, aresetn, s_axis_tready, state_reg == ST_IDLE)
    `PEE_ASSERT_NEXT(a_emit_clears, aclk, aresetn,
        state_reg == ST_EMIT && state_next == ST_IDLE, sp_reg == '0 && flg_reg == '0)
    `PEE_ASSERT_IMPL(a_op_depth, aclk, aresetn, state_reg == ST_READ_B, sp_reg >= PTR_W'(2))

endmodule

[tb/postfix_expression_evaluator_top_tb.sv]
// ============================================================================
// postfix_expression_evaluator_top_tb
// Drives postfix expressions one character per word and checks each result
// word against an internal evaluator of the same fixed-point rules.
// ============================================================================
module postfix_expression_evaluator_top_tb;
    import pee_pkg::*;

    typedef struct {
        logic signed [31:0] value;
        logic [4:0]         flags;
    } answer_t;

    typedef struct {
        logic [7:0] sym;
        logic       last;
        logic       known;
        logic signed [31:0] value;
        logic [4:0]         flags;
    } row_t;

    localparam int CYCLE_LIMIT = 3000000;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;
    logic        s_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;
    logic [4:0]  m_axis_tuser;

    postfix_expression_evaluator_top dut (.*);

    logic signed [31:0] opnd [STACK_DEPTH];
    int                 depth;
    logic signed [31:0] recent;
    logic [4:0]         sticky;
    answer_t            answers [$];
    int                 errors = 0;
    int                 cycles = 0;
    int                 send_idle;
    int                 recv_idle;
    int                 hold_off;
    bit                 hold_armed;
    bit                 pressure = 1'b0;
    row_t               rows [$];

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        if (v > 66'sd2147483647) begin
            sticky[FLG_SAT] = 1'b1;
            return VAL_MAX;
        end
        if (v < -66'sd2147483648) begin
            sticky[FLG_SAT] = 1'b1;
            return VAL_MIN;
        end
        return v[31:0];
    endfunction

    function automatic logic [63:0] magn(input logic signed [31:0] a);
        logic signed [63:0] w;
        w = a;
        return (w < 0) ? -w : w;
    endfunction

    function automatic logic signed [31:0] signed_of(input logic [63:0] m, input bit neg);
        logic signed [65:0] v;
        v = {2'b00, m};
        return sat32(neg ? -v : v);
    endfunction

    function automatic logic signed [31:0] qmul(input logic signed [31:0] a,
                                               input logic signed [31:0] b);
        return signed_of((magn(a) * magn(b)) >> FRAC_BITS, (a < 0) != (b < 0));
    endfunction

    function automatic logic signed [31:0] qdiv(input logic signed [31:0] a,
                                               input logic signed [31:0] b);
        if (b == 0) begin
            sticky[FLG_DIV0] = 1'b1;
            return (a > 0) ? VAL_MAX : (a < 0) ? VAL_MIN : 32'sd0;
        end
        return signed_of((magn(a) << FRAC_BITS) / magn(b), (a < 0) != (b < 0));
    endfunction

    function automatic logic signed [31:0] qpow(input logic signed [31:0] a,
                                               input logic signed [31:0] b);
        logic [63:0]        n;
        logic signed [31:0] r;
        n = 0;
        r = a;
        if (b > 0) begin
            n = ((64'(b) + (64'd1 << FRAC_BITS) - 1) >> FRAC_BITS) - 1;
            if (n > 255) n = 255;
        end
        for (int i = 0; i < n; i++) r = qmul(r, a);
        return r;
    endfunction

    function automatic void evaluate_symbol(input logic [7:0] sym, input logic last);
        logic signed [31:0] a;
        logic signed [31:0] b;
        logic signed [31:0] r;
        answer_t            ans;
        if (sym >= SYM_ZERO && sym <= SYM_NINE) begin
            if (depth >= STACK_DEPTH) begin
                sticky[FLG_FULL] = 1'b1;
            end else begin
                opnd[depth] = 32'(sym - SYM_ZERO) <<< FRAC_BITS;
                depth++;
            end
        end else if (sym == SYM_ADD || sym == SYM_SUB || sym == SYM_MUL ||
                     sym == SYM_DIV || sym == SYM_POW) begin
            if (depth < 2) begin
                sticky[FLG_UNDER] = 1'b1;
            end else begin
                b = opnd[depth-1];
                a = opnd[depth-2];
                case (sym)
                    SYM_ADD: r = sat32(66'(a) + 66'(b));
                    SYM_SUB: r = sat32(66'(a) - 66'(b));
                    SYM_MUL: r = qmul(a, b);
                    SYM_DIV: r = qdiv(a, b);
                    default: r = qpow(a, b);
                endcase
                depth--;
                opnd[depth-1] = r;
                recent = r;
            end
        end else if (sym != SYM_SPACE) begin
            sticky[FLG_BAD] = 1'b1;
        end
        if (last) begin
            ans.value = recent;
            ans.flags = sticky;
            answers.push_back(ans);
            depth = 0;
            recent = 0;
            sticky = 0;
        end
    endfunction

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("mismatch on %s: got %h, expected %h", what, got, want);
        errors++;
    endtask

    task automatic send_word(input logic [7:0] sym, input logic last);
        while ($urandom_range(99) < send_idle) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= sym;
        s_axis_tlast  <= last;
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        evaluate_symbol(sym, last);
    endtask

    function automatic logic [7:0] pick_symbol(input int mode);
        int k;
        k = $urandom_range(99);
        if (mode == 1) return 8'($urandom_range(255));
        if (k < 45) return SYM_ZERO + 8'($urandom_range(9));
        if (k < 50) return SYM_SPACE;
        if (k < 58) return SYM_ADD;
        if (k < 66) return SYM_SUB;
        if (k < 78) return SYM_MUL;
        if (k < 87) return SYM_DIV;
        if (k < 93) return SYM_POW;
        return 8'($urandom_range(255));
    endfunction

    task automatic send_expression(input int len, input int mode);
        for (int i = 0; i < len; i++) send_word(pick_symbol(mode), i == len - 1);
    endtask

    function automatic void add_row(input logic [7:0] s, input logic l, input logic k,
                                    input logic [31:0] v, input logic [4:0] f);
        row_t r;
        r.sym = s;
        r.last = l;
        r.known = k;
        r.value = v;
        r.flags = f;
        rows.push_back(r);
    endfunction

    always @(posedge aclk) begin
        answer_t want;
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
            hold_off <= 0;
            hold_armed <= 1'b1;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (answers.size() == 0) begin
                    report("unexpected word", m_axis_tdata, 32'd0);
                end else begin
                    want = answers.pop_front();
                    if (m_axis_tdata !== want.value) report("value", m_axis_tdata, want.value);
                    if (m_axis_tuser !== want.flags)
                        report("flags", 32'(m_axis_tuser), 32'(want.flags));
                end
            end
            if (hold_armed && pressure) begin
                hold_armed <= 1'b0;
                hold_off <= 400;
                m_axis_tready <= 1'b0;
            end else if (hold_off > 0) begin
                hold_off <= hold_off - 1;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= recv_idle);
            end
        end
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        depth = 0;
        recent = 0;
        sticky = 0;
        send_idle = 0;
        recv_idle = 0;
        aresetn = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = 8'd0;
        s_axis_tlast = 1'b0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        add_row(SYM_SPACE, 1'b1, 1'b1, 32'd0, 5'b00000);
        add_row(SYM_ADD, 1'b1, 1'b1, 32'd0, 5'b00010);
        add_row(8'hFF, 1'b1, 1'b1, 32'd0, 5'b00001);
        add_row(8'h00, 1'b1, 1'b1, 32'd0, 5'b00001);
        add_row(SYM_NINE, 1'b0, 1'b0, 32'd0, 5'b00000);
        add_row(SYM_ZERO, 1'b0, 1'b0, 32'd0, 5'b00000);
        add_row(SYM_DIV, 1'b1, 1'b1, VAL_MAX, 5'b01000);
        add_row(SYM_ZERO, 1'b0, 1'b0, 32'd0, 5'b00000);
        add_row(SYM_ZERO, 1'b0, 1'b0, 32'd0, 5'b00000);
        add_row(SYM_DIV, 1'b1, 1'b1, 32'd0, 5'b01000);
        add_row(SYM_NINE, 1'b0, 1'b0, 32'd0, 5'b00000);
        add_row(SYM_NINE, 1'b0, 1'b0, 32'd0, 5'b00000);
        add_row(SYM_POW, 1'b1, 1'b1, VAL_MAX, 5'b10000);
        add_row(SYM_ZERO, 1'b0, 1'b0, 32'd0, 5'b00000);
        add_row(SYM_NINE, 1'b0, 1'b0, 32'd0, 5'b00000);
        add_row(SYM_SUB, 1'b0, 1'b0, 32'd0, 5'b00000);
        add_row(SYM_NINE, 1'b0, 1'b0, 32'd0, 5'b00000);
        add_row(SYM_POW, 1'b1, 1'b1, VAL_MIN, 5'b10000);
        add_row(SYM_ZERO + 8'd7, 1'b0, 1'b0, 32'd0, 5'b00000);
        add_row(SYM_NINE - 8'd6, 1'b0, 1'b0, 32'd0, 5'b00000);
        add_row(SYM_MUL, 1'b0, 1'b0, 32'd0, 5'b00000);
        add_row(SYM_NINE - 8'd7, 1'b0, 1'b0, 32'd0, 5'b00000);
        add_row(SYM_DIV, 1'b1, 1'b0, 32'd0, 5'b00000);
        add_row(8'h7F, 1'b0, 1'b0, 32'd0, 5'b00000);
        add_row(8'h80, 1'b1, 1'b0, 32'd0, 5'b00000);
        foreach (rows[i]) begin
            if (rows[i].known && rows[i].last) begin
                send_word(rows[i].sym, rows[i].last);
                void'(answers.pop_back());
                answers.push_back('{rows[i].value, rows[i].flags});
            end else begin
                send_word(rows[i].sym, rows[i].last);
            end
        end

        for (int i = 0; i < STACK_DEPTH + 2; i++) send_word(SYM_ZERO + 8'd1, 1'b0);
        send_word(SYM_ADD, 1'b1);

        for (int phase = 0; phase < 3; phase++) begin
            send_idle = (phase == 0) ? 34 : (phase == 1) ? 72 : 0;
            recv_idle = (phase == 0) ? 72 : (phase == 1) ? 34 : 0;
            if (phase == 2) pressure = 1'b1;
            for (int n = 0; n < 50; n++)
                send_expression($urandom_range(3, 13), ($urandom_range(9) == 0) ? 1 : 0);
        end
        s_axis_tvalid <= 1'b0;
        while (answers.size() != 0) @(posedge aclk);
        repeat (600) @(posedge aclk);
        if (errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule
